// ===== rtl/core/obbsat_pkg.sv =====
// Shared widths and axis codes for the oriented box overlap pipeline.
// No dependencies; imported by obbsat_extent and obb2d_overlap_sat_unit.
package obbsat_pkg;

    // Input field widths
    localparam int CRD_W  = 24;   // center coordinate, signed Q15.8
    localparam int AXIS_W = 16;   // right axis component, signed Q1.14
    localparam int SIZE_W = 24;   // full width or height, unsigned Q16.8

    // Internal widths
    localparam int DIFF_W = CRD_W + 1;          // center difference
    localparam int APRD_W = 2 * AXIS_W;         // axis by axis product
    localparam int GRAM_W = 2 * AXIS_W;         // |axis . axis|, up to 2^31
    localparam int DPRD_W = DIFF_W + AXIS_W;    // difference by axis product
    localparam int DIST_W = DPRD_W;             // |difference . axis|, up to 2^40
    localparam int SPRD_W = SIZE_W + GRAM_W;    // size by gram term
    localparam int EXT_W  = SPRD_W + 2;         // sum of three size terms
    localparam int SCALE_SH = 15;               // Q.22 -> Q.36 and the factor two

    // Test axes
    localparam int NUM_AX = 4;
    localparam int AX_R1  = 0;    // first right
    localparam int AX_U1  = 1;    // first up
    localparam int AX_R2  = 2;    // second right
    localparam int AX_U2  = 3;    // second up

    typedef logic [NUM_AX-1:0][EXT_W-1:0]  t_ext_vec;
    typedef logic [NUM_AX-1:0][DIST_W-1:0] t_dist_vec;

endpackage

// ===== rtl/core/obb2d_overlap_sat_unit.sv =====
// Top level of the 2D oriented box overlap test (separating axis test).
// Depends on obbsat_pkg and obbsat_extent.
//
// Takes one box pair per clock while o_stall is low and returns one overlap
// flag per pair. The pipeline is five register stages deep; every stage
// holds one pair, so throughput is one item per cycle with no gaps unless
// stalled, set by the fully pipelined multiplier stages (axis products, then
// size and distance products). When the downstream side stalls while a result
// is waiting in the output register, the whole pipeline freezes in place and
// o_stall is raised; nothing is dropped or repeated. Results are exact: the
// four axes (first right, first up, second right, second up) are tested with
// full-width integer products, and a pair counts as overlapping unless the
// projected center distance is strictly greater than the summed projected
// half extents on some axis, so touching boxes overlap. The block holds no
// state besides the pipeline itself.
module obb2d_overlap_sat_unit
    import obbsat_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,

    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic signed [CRD_W-1:0]  i_first_center_x,
    input  logic signed [CRD_W-1:0]  i_first_center_y,
    input  logic signed [AXIS_W-1:0] i_first_axis_x,
    input  logic signed [AXIS_W-1:0] i_first_axis_y,
    input  logic        [SIZE_W-1:0] i_first_width,
    input  logic        [SIZE_W-1:0] i_first_height,
    input  logic signed [CRD_W-1:0]  i_second_center_x,
    input  logic signed [CRD_W-1:0]  i_second_center_y,
    input  logic signed [AXIS_W-1:0] i_second_axis_x,
    input  logic signed [AXIS_W-1:0] i_second_axis_y,
    input  logic        [SIZE_W-1:0] i_second_width,
    input  logic        [SIZE_W-1:0] i_second_height,

    output logic                     o_valid,
    input  logic                     i_stall,
    output logic                     o_overlap
);

    localparam int NUM_STG = 5;

    // distance product slots
    localparam int PR_DX_A1X = 0;
    localparam int PR_DY_A1Y = 1;
    localparam int PR_DY_A1X = 2;
    localparam int PR_DX_A1Y = 3;
    localparam int PR_DX_A2X = 4;
    localparam int PR_DY_A2Y = 5;
    localparam int PR_DY_A2X = 6;
    localparam int PR_DX_A2Y = 7;
    localparam int NUM_PR    = 8;

    // valid bit per stage; the last one is the output register
    logic [NUM_STG-1:0] r_vld;
    logic               w_en;

    // stage 1
    logic signed [DIFF_W-1:0] r_dx, r_dy;
    logic signed [AXIS_W-1:0] r_a1x, r_a1y, r_a2x, r_a2y;
    logic signed [DIFF_W-1:0] n_dx, n_dy;

    // stage 2
    logic signed [DPRD_W-1:0] r_pr [NUM_PR];

    // stage 3 and 4: distance magnitudes per axis
    t_dist_vec r_dist3, r_dist4;
    t_dist_vec n_dist;

    // stage 5
    logic r_overlap;

    t_ext_vec          w_ext;
    logic [NUM_AX-1:0] w_sep;

    // projected center distance before abs, one per test axis
    logic signed [DPRD_W:0] w_proj [NUM_AX];
    logic signed [DPRD_W:0] w_proj_neg [NUM_AX];

    // The pipeline moves unless a finished result is held by the stall.
    assign w_en    = !(r_vld[NUM_STG-1] && i_stall);
    assign o_stall = !w_en;

    assign n_dx = DIFF_W'(i_second_center_x) - DIFF_W'(i_first_center_x);
    assign n_dy = DIFF_W'(i_second_center_y) - DIFF_W'(i_first_center_y);

    always_comb begin
        // right axis (x, y) and up axis (-y, x)
        w_proj[AX_R1] = (DPRD_W+1)'(r_pr[PR_DX_A1X]) + (DPRD_W+1)'(r_pr[PR_DY_A1Y]);
        w_proj[AX_U1] = (DPRD_W+1)'(r_pr[PR_DY_A1X]) - (DPRD_W+1)'(r_pr[PR_DX_A1Y]);
        w_proj[AX_R2] = (DPRD_W+1)'(r_pr[PR_DX_A2X]) + (DPRD_W+1)'(r_pr[PR_DY_A2Y]);
        w_proj[AX_U2] = (DPRD_W+1)'(r_pr[PR_DY_A2X]) - (DPRD_W+1)'(r_pr[PR_DX_A2Y]);
        for (int k = 0; k < NUM_AX; k++) begin
            w_proj_neg[k] = -w_proj[k];
            n_dist[k] = w_proj[k][DPRD_W] ? w_proj_neg[k][DIST_W-1:0]
                                          : w_proj[k][DIST_W-1:0];
        end
        // dist is Q.22, extent sum is twice the half extents in Q.36
        for (int k = 0; k < NUM_AX; k++) begin
            w_sep[k] = EXT_W'({r_dist4[k], {SCALE_SH{1'b0}}}) > w_ext[k];
        end
    end

    obbsat_extent u_extent (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_a1x (i_first_axis_x),
        .i_a1y (i_first_axis_y),
        .i_a2x (i_second_axis_x),
        .i_a2y (i_second_axis_y),
        .i_w1  (i_first_width),
        .i_h1  (i_first_height),
        .i_w2  (i_second_width),
        .i_h2  (i_second_height),
        .o_ext (w_ext)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NUM_STG-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dx  <= n_dx;
            r_dy  <= n_dy;
            r_a1x <= i_first_axis_x;
            r_a1y <= i_first_axis_y;
            r_a2x <= i_second_axis_x;
            r_a2y <= i_second_axis_y;

            r_pr[PR_DX_A1X] <= r_dx * r_a1x;
            r_pr[PR_DY_A1Y] <= r_dy * r_a1y;
            r_pr[PR_DY_A1X] <= r_dy * r_a1x;
            r_pr[PR_DX_A1Y] <= r_dx * r_a1y;
            r_pr[PR_DX_A2X] <= r_dx * r_a2x;
            r_pr[PR_DY_A2Y] <= r_dy * r_a2y;
            r_pr[PR_DY_A2X] <= r_dy * r_a2x;
            r_pr[PR_DX_A2Y] <= r_dx * r_a2y;

            r_dist3 <= n_dist;
            r_dist4 <= r_dist3;

            // overlap unless some axis separates
            r_overlap <= ~|w_sep;
        end
    end

    assign o_valid   = r_vld[NUM_STG-1];
    assign o_overlap = r_overlap;

endmodule

// ===== rtl/core/obbsat_extent.sv =====
// Four stage extent pipeline: summed projected box sizes on each test axis.
// Depends on obbsat_pkg; instantiated by obb2d_overlap_sat_unit.
module obbsat_extent
    import obbsat_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [AXIS_W-1:0] i_a1x,
    input  logic signed [AXIS_W-1:0] i_a1y,
    input  logic signed [AXIS_W-1:0] i_a2x,
    input  logic signed [AXIS_W-1:0] i_a2y,
    input  logic        [SIZE_W-1:0] i_w1,
    input  logic        [SIZE_W-1:0] i_h1,
    input  logic        [SIZE_W-1:0] i_w2,
    input  logic        [SIZE_W-1:0] i_h2,
    output t_ext_vec                 o_ext
);

    // stage 1: axis products
    logic signed [APRD_W-1:0] r_p1xx, r_p1yy, r_p2xx, r_p2yy;
    logic signed [APRD_W-1:0] r_pxx, r_pyy, r_pxy, r_pyx;
    logic [SIZE_W-1:0] r_w1_s1, r_h1_s1, r_w2_s1, r_h2_s1;

    // stage 2: squared norms and |cos|, |sin| terms (scaled)
    logic [GRAM_W-1:0] r_n1, r_n2, r_cm, r_sm;
    logic [SIZE_W-1:0] r_w1_s2, r_h1_s2, r_w2_s2, r_h2_s2;

    // stage 3: size products
    logic [SPRD_W-1:0] r_w1n1, r_h1n1, r_w2n2, r_h2n2;
    logic [SPRD_W-1:0] r_w1c, r_w1s, r_h1c, r_h1s, r_w2c, r_w2s, r_h2c, r_h2s;

    // stage 4
    t_ext_vec r_ext;

    logic signed [APRD_W:0] w_c, w_s, w_c_neg, w_s_neg;
    logic [GRAM_W-1:0] n_n1, n_n2, n_cm, n_sm;
    t_ext_vec n_ext;

    always_comb begin
        w_c     = $signed({r_pxx[APRD_W-1], r_pxx}) + $signed({r_pyy[APRD_W-1], r_pyy});
        w_s     = $signed({r_pxy[APRD_W-1], r_pxy}) - $signed({r_pyx[APRD_W-1], r_pyx});
        w_c_neg = -w_c;
        w_s_neg = -w_s;
        // squares are non-negative and at most 2^30
        n_n1 = {1'b0, r_p1xx[APRD_W-2:0]} + {1'b0, r_p1yy[APRD_W-2:0]};
        n_n2 = {1'b0, r_p2xx[APRD_W-2:0]} + {1'b0, r_p2yy[APRD_W-2:0]};
        n_cm = w_c[APRD_W] ? w_c_neg[GRAM_W-1:0] : w_c[GRAM_W-1:0];
        n_sm = w_s[APRD_W] ? w_s_neg[GRAM_W-1:0] : w_s[GRAM_W-1:0];

        n_ext[AX_R1] = EXT_W'(r_w1n1) + EXT_W'(r_w2c) + EXT_W'(r_h2s);
        n_ext[AX_U1] = EXT_W'(r_h1n1) + EXT_W'(r_w2s) + EXT_W'(r_h2c);
        n_ext[AX_R2] = EXT_W'(r_w1c)  + EXT_W'(r_h1s) + EXT_W'(r_w2n2);
        n_ext[AX_U2] = EXT_W'(r_w1s)  + EXT_W'(r_h1c) + EXT_W'(r_h2n2);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1xx  <= i_a1x * i_a1x;
            r_p1yy  <= i_a1y * i_a1y;
            r_p2xx  <= i_a2x * i_a2x;
            r_p2yy  <= i_a2y * i_a2y;
            r_pxx   <= i_a1x * i_a2x;
            r_pyy   <= i_a1y * i_a2y;
            r_pxy   <= i_a1x * i_a2y;
            r_pyx   <= i_a1y * i_a2x;
            r_w1_s1 <= i_w1;
            r_h1_s1 <= i_h1;
            r_w2_s1 <= i_w2;
            r_h2_s1 <= i_h2;

            r_n1    <= n_n1;
            r_n2    <= n_n2;
            r_cm    <= n_cm;
            r_sm    <= n_sm;
            r_w1_s2 <= r_w1_s1;
            r_h1_s2 <= r_h1_s1;
            r_w2_s2 <= r_w2_s1;
            r_h2_s2 <= r_h2_s1;

            r_w1n1 <= r_w1_s2 * r_n1;
            r_h1n1 <= r_h1_s2 * r_n1;
            r_w2n2 <= r_w2_s2 * r_n2;
            r_h2n2 <= r_h2_s2 * r_n2;
            r_w1c  <= r_w1_s2 * r_cm;
            r_w1s  <= r_w1_s2 * r_sm;
            r_h1c  <= r_h1_s2 * r_cm;
            r_h1s  <= r_h1_s2 * r_sm;
            r_w2c  <= r_w2_s2 * r_cm;
            r_w2s  <= r_w2_s2 * r_sm;
            r_h2c  <= r_h2_s2 * r_cm;
            r_h2s  <= r_h2_s2 * r_sm;

            r_ext <= n_ext;
        end
    end

    assign o_ext = r_ext;

endmodule
